@@ sv/kvl_pkg.sv @@
// ----------------------------------------------------------------------------
// kvl_pkg
// Shared types and constants for the keyframe vector interpolator.
// ----------------------------------------------------------------------------
package kvl_pkg;
  localparam int MAX_KEYS   = 16;
  localparam int MAX_COORDS = 64;
  localparam int KW = $clog2(MAX_KEYS);
  localparam int CW = $clog2(MAX_COORDS);
  localparam int KEY_DEPTH = MAX_KEYS;
  localparam int CRD_DEPTH = MAX_KEYS * MAX_COORDS;
  localparam int CAW = $clog2(CRD_DEPTH);

  localparam logic [1:0] CMD_KEY   = 2'd0;
  localparam logic [1:0] CMD_COORD = 2'd1;
  localparam logic [1:0] CMD_APPLY = 2'd2;

  localparam logic [1:0] CFG_KEY_COUNT = 2'd0;
  localparam logic [1:0] CFG_COORDS    = 2'd1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_K0, ST_KL, ST_SRCH, ST_SCMP, ST_DIV, ST_CRD, ST_CRDW, ST_MUL, ST_OUT
  } state_t;

  typedef enum logic [1:0] {MD_FIRST, MD_LAST, MD_LERP, MD_ZERO} mode_t;

  // divider request and response handshake
  typedef struct packed {
    logic        start;
    logic [32:0] num;
    logic [32:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [16:0] quo;
  } div_rsp_t;
endpackage

@@ sv/keyframe_vector_lerp.sv @@
// ----------------------------------------------------------------------------
// keyframe_vector_lerp
// Piecewise linear keyframe interpolation of vec3 coordinate sets.
// ----------------------------------------------------------------------------
// channel  dir  fields (tdata low bit up)
// in_      in   cmd, key_index, coord_index, component, data_value, fraction
// out_     out  out_index, out_x, out_y, out_z; tlast = last
// cfg_     in   index (2 bit), data (7 bit)
// An apply compares keys for the search, runs the divider on a nonzero
// interval, then interpolates each coordinate (or copies a set or gives
// zeros); an output stall holds it. Key and coordinate memories are
// single port.
// Reset is synchronous; memories hold garbage until written.
// ----------------------------------------------------------------------------
module keyframe_vector_lerp import kvl_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // cmd[1:0] key_index[5:2] coord_index[11:6] component[13:12]
  // data_value[45:14] fraction[77:46]
  input  logic [79:0]   in_tdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  // out_index[5:0] out_x[37:6] out_y[69:38] out_z[101:70]
  output logic [103:0]  out_tdata,
  output logic          out_tlast,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [6:0]    cfg_data
);
  state_t st_r, st_nxt;
  mode_t  md_r, md_nxt;
  logic [4:0] kc_r; logic [6:0] cpk_r;
  logic signed [31:0] frac_r, frac_nxt, k0_r, k0_nxt, kp_r, kp_nxt;
  logic [KW-1:0] ki_r, ki_nxt, seg_r, seg_nxt, last_k;
  logic [CW-1:0] j_r, j_nxt;
  logic [1:0] c_r, c_nxt;
  logic hi_r, hi_nxt;
  logic [16:0] f_r, f_nxt;
  logic signed [31:0] res_r [3];
  logic signed [31:0] res_nxt [3];
  logic [79:0] d_r, d_nxt;

  logic kwe, cwe [3];
  logic [KW-1:0] kaddr;
  logic [CAW-1:0] caddr;
  logic [31:0] kwd, krd;
  logic [31:0] crd [3];
  div_req_t dreq; div_rsp_t drsp;

  logic [1:0] f_cmd, f_comp; logic [3:0] f_ki; logic [5:0] f_ci;
  assign f_cmd = d_r[1:0]; assign f_ki = d_r[5:2]; assign f_ci = d_r[11:6];
  assign f_comp = d_r[13:12];

  logic [4:0] nk; logic [6:0] nc;
  assign nk = (kc_r == 5'd0) ? 5'd1 : (kc_r > 5'(MAX_KEYS) ? 5'(MAX_KEYS) : kc_r);
  assign nc = (cpk_r == 7'd0) ? 7'd1 : (cpk_r > 7'(MAX_COORDS) ? 7'(MAX_COORDS) : cpk_r);
  assign last_k = KW'(nk - 5'd1);

  kvl_ram #(.WIDTH(32), .DEPTH(KEY_DEPTH)) u_key (
    .clk(clk), .we(kwe), .addr(kaddr), .wdata(kwd), .rdata(krd));
  for (genvar g = 0; g < 3; g++) begin : g_crd
    kvl_ram #(.WIDTH(32), .DEPTH(CRD_DEPTH)) u_crd (
      .clk(clk), .we(cwe[g]), .addr(caddr), .wdata(kwd), .rdata(crd[g]));
  end
  kvl_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign cfg_ready = (st_r == ST_IDLE);
  assign in_tready = (st_r == ST_IDLE);

  // one component per cycle: v1 + floor((v2 - v1) * f / 65536)
  logic signed [31:0] va, vb;
  logic signed [32:0] dlt;
  logic signed [50:0] prod;
  logic signed [34:0] lerp_sum;
  always_comb begin
    case (c_r)
      2'd0: begin va = res_r[0]; vb = crd[0]; end
      2'd1: begin va = res_r[1]; vb = crd[1]; end
      default: begin va = res_r[2]; vb = crd[2]; end
    endcase
    dlt = $signed({vb[31], vb}) - $signed({va[31], va});
    prod = dlt * $signed({1'b0, f_r});
    lerp_sum = $signed({{3{va[31]}}, va}) + 35'(prod >>> 16);
  end

  always_comb begin
    st_nxt = st_r; md_nxt = md_r; frac_nxt = frac_r; k0_nxt = k0_r; kp_nxt = kp_r;
    ki_nxt = ki_r; seg_nxt = seg_r; j_nxt = j_r; c_nxt = c_r; hi_nxt = hi_r;
    f_nxt = f_r; d_nxt = d_r;
    for (int i = 0; i < 3; i++) res_nxt[i] = res_r[i];
    kwe = 1'b0; for (int i = 0; i < 3; i++) cwe[i] = 1'b0;
    // hold the upper set on the read port while the lerp runs
    kaddr = ki_r; caddr = {(md_r == MD_LERP) ? seg_r + KW'(1) : seg_r, j_r};
    kwd = d_r[45:14];
    dreq = '0;
    case (st_r)
      ST_IDLE: if (in_tvalid) begin
        d_nxt = in_tdata; frac_nxt = in_tdata[77:46];
        st_nxt = (in_tdata[1:0] == CMD_APPLY) ? ST_K0 :
                 (in_tdata[1:0] == CMD_KEY || in_tdata[1:0] == CMD_COORD) ? ST_CRDW
                 : ST_IDLE;
        kaddr = '0;
      end
      ST_CRDW: begin
        if (f_cmd == CMD_KEY) begin
          kaddr = f_ki; kwe = 1'b1;
        end else begin
          caddr = {f_ki, f_ci};
          for (int i = 0; i < 3; i++) cwe[i] = (f_comp == 2'(i));
        end
        st_nxt = ST_IDLE;
      end
      ST_K0: begin
        kaddr = '0; st_nxt = ST_KL;
      end
      ST_KL: begin
        k0_nxt = krd; kaddr = last_k; st_nxt = ST_SRCH;
      end
      ST_SRCH: begin
        // krd = key[last]
        if (frac_r < k0_r) begin md_nxt = MD_FIRST; seg_nxt = '0; st_nxt = ST_CRD; end
        else if (frac_r > $signed(krd)) begin
          md_nxt = MD_LAST; seg_nxt = last_k; st_nxt = ST_CRD;
        end else if (last_k == '0) begin md_nxt = MD_ZERO; st_nxt = ST_CRD; end
        else begin
          kp_nxt = k0_r; ki_nxt = KW'(1); kaddr = KW'(1); st_nxt = ST_SCMP;
        end
        j_nxt = '0; c_nxt = '0; hi_nxt = 1'b0;
      end
      ST_SCMP: begin
        // interval [kp, krd] with lower index ki-1
        if (kp_r <= frac_r && frac_r <= $signed(krd)) begin
          seg_nxt = ki_r - KW'(1); md_nxt = MD_LERP;
          if ($signed(krd) > kp_r) begin
            dreq.start = 1'b1;
            dreq.num = $signed({frac_r[31], frac_r}) - $signed({kp_r[31], kp_r});
            dreq.den = $signed({krd[31], krd}) - $signed({kp_r[31], kp_r});
            st_nxt = ST_DIV;
          end else begin f_nxt = '0; st_nxt = ST_CRD; end
        end else if (ki_r == last_k) begin md_nxt = MD_ZERO; st_nxt = ST_CRD; end
        else begin
          kp_nxt = krd; ki_nxt = ki_r + KW'(1); kaddr = ki_r + KW'(1);
        end
      end
      ST_DIV: if (drsp.done) begin f_nxt = drsp.quo; st_nxt = ST_CRD; end
      ST_CRD: begin
        // read seg or seg+1 set for coordinate j
        caddr = {hi_r ? seg_r + KW'(1) : seg_r, j_r};
        st_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (md_r == MD_ZERO) begin
          for (int i = 0; i < 3; i++) res_nxt[i] = '0;
          st_nxt = ST_OUT;
        end else if (md_r != MD_LERP) begin
          for (int i = 0; i < 3; i++) res_nxt[i] = crd[i];
          st_nxt = ST_OUT;
        end else if (!hi_r) begin
          for (int i = 0; i < 3; i++) res_nxt[i] = crd[i];
          hi_nxt = 1'b1; st_nxt = ST_CRD;
        end else begin
          // res holds v1, crd holds v2
          hi_nxt = 1'b0; c_nxt = '0; st_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (md_r == MD_LERP && c_r != 2'd3) begin
          for (int i = 0; i < 3; i++) begin
            if (c_r == 2'(i)) begin
              res_nxt[i] = (lerp_sum > 35'sd2147483647) ? 32'sh7FFFFFFF :
                           (lerp_sum < -35'sd2147483648) ? 32'sh80000000 :
                           lerp_sum[31:0];
            end
          end
          c_nxt = c_r + 2'd1;
        end else if (out_tready) begin
          if (7'(j_r) + 7'd1 == nc) st_nxt = ST_IDLE;
          else begin j_nxt = j_r + CW'(1); st_nxt = ST_CRD; end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; kc_r <= 5'd2; cpk_r <= 7'd1;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_KEY_COUNT) kc_r <= cfg_data[4:0];
        else if (cfg_index == CFG_COORDS) cpk_r <= cfg_data;
      end
    end
    md_r <= md_nxt; frac_r <= frac_nxt; k0_r <= k0_nxt; kp_r <= kp_nxt; ki_r <= ki_nxt;
    seg_r <= seg_nxt; j_r <= j_nxt; c_r <= c_nxt; hi_r <= hi_nxt; f_r <= f_nxt;
    d_r <= d_nxt;
    for (int i = 0; i < 3; i++) res_r[i] <= res_nxt[i];
  end

  assign out_tvalid = (st_r == ST_OUT) && !(md_r == MD_LERP && c_r != 2'd3);
  assign out_tdata = {2'b0, res_r[2], res_r[1], res_r[0], j_r};
  assign out_tlast = (7'(j_r) + 7'd1 == nc);

`ifndef SYNTHESIS
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("ready during output");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output dropped");
  a_div: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.done |-> st_r == ST_DIV) else $error("stray divider result");
`endif
endmodule

@@ sv/kvl_ram.sv @@
// ----------------------------------------------------------------------------
// kvl_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module kvl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

@@ sv/kvl_div.sv @@
// ----------------------------------------------------------------------------
// kvl_div
// Restoring divider, one quotient bit per cycle, 17-bit quotient.
// ----------------------------------------------------------------------------
module kvl_div import kvl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);
  // num <= den, so num * 65536 / den fits 17 bits
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [32:0] den_r, den_nxt;
  logic [16:0] q_r, q_nxt;
  logic        done_r, done_nxt;
  logic [33:0] trial;

  always_comb begin
    cnt_nxt = cnt_r; busy_nxt = busy_r; rem_nxt = rem_r; den_nxt = den_r;
    q_nxt = q_r; done_nxt = 1'b0;
    // integer bit first, then shift in one zero per fraction bit
    trial = (cnt_r == 5'd0) ? rem_r : {rem_r[32:0], 1'b0};
    if (req.start) begin
      busy_nxt = 1'b1; cnt_nxt = 5'd0;
      rem_nxt = {1'b0, req.num}; den_nxt = req.den; q_nxt = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt = {q_r[15:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[15:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd16) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt; den_r <= den_nxt; q_r <= q_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = q_r;
endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for keyframe_vector_lerp. Loads key tables and
// coordinate sets, applies directed and random fractions under several
// register settings and random stalls on both streams, and checks every
// result transfer against a cycle-free predictor of the interpolator.
// ----------------------------------------------------------------------------
module testbench;
  import kvl_pkg::*;

  localparam logic [1:0] CMD_NONE   = 2'd3;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic [1:0]         cmd;
    logic [3:0]         key_index;
    logic [5:0]         coord_index;
    logic [1:0]         component;
    logic signed [31:0] data_value;
    logic signed [31:0] fraction;
  } lerp_cmd_t;

  typedef struct {
    logic [5:0]         index;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               last;
  } coord_res_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  // cmd, key_index, coord_index, component, data_value, fraction
  logic [79:0]   in_tdata = '0;
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  // out_index, out_x, out_y, out_z
  logic [103:0]  out_tdata;
  logic          out_tlast;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [1:0]    cfg_index = '0;
  logic [6:0]    cfg_data = '0;

  keyframe_vector_lerp dut (.*);

  always #5 clk = ~clk;

  // interpolator state as the block should hold it
  logic signed [31:0] key_mem [MAX_KEYS];
  logic signed [31:0] crd_mem [MAX_KEYS][MAX_COORDS][3];
  logic [4:0]         key_count_q = 5'd2;
  logic [6:0]         coords_q = 7'd1;

  // generator shadow of what has been written
  longint gen_keys [MAX_KEYS];
  bit     crd_written [MAX_KEYS][MAX_COORDS][3];
  int     gen_nk = 2;
  int     gen_nc = 1;

  lerp_cmd_t  pend_q [$];
  coord_res_t coord_q [$];
  lerp_cmd_t  cur;
  int send_pct = 8;
  int recv_pct = 82;
  int errors = 0;
  int cycles = 0;

  function automatic void predict_item(lerp_cmd_t it);
    int nk, nc, lastk, seg, j, c, i;
    mode_t md;
    longint fr, f, den, num, v1, v2, r;
    coord_res_t o;
    case (it.cmd)
      CMD_KEY: key_mem[it.key_index] = it.data_value;
      CMD_COORD: begin
        if (it.component != 2'd3)
          crd_mem[it.key_index][it.coord_index][it.component] = it.data_value;
      end
      CMD_APPLY: begin
        nk = (key_count_q < 1) ? 1 : (key_count_q > MAX_KEYS) ? MAX_KEYS : key_count_q;
        nc = (coords_q < 1) ? 1 : (coords_q > MAX_COORDS) ? MAX_COORDS : coords_q;
        lastk = nk - 1;
        seg = 0;
        f = 0;
        fr = it.fraction;
        if (fr < longint'(key_mem[0])) begin
          md = MD_FIRST;
        end else if (fr > longint'(key_mem[lastk])) begin
          md = MD_LAST;
        end else begin
          md = MD_ZERO;
          for (i = 0; i < lastk; i++) begin
            if (md == MD_ZERO && longint'(key_mem[i]) <= fr && fr <= longint'(key_mem[i+1])) begin
              den = longint'(key_mem[i+1]) - longint'(key_mem[i]);
              num = fr - longint'(key_mem[i]);
              f = (den > 0) ? (num * 65536) / den : 0;
              seg = i;
              md = MD_LERP;
            end
          end
        end
        for (j = 0; j < nc; j++) begin
          o.index = j[5:0];
          for (c = 0; c < 3; c++) begin
            case (md)
              MD_FIRST: r = crd_mem[0][j][c];
              MD_LAST:  r = crd_mem[lastk][j][c];
              MD_LERP: begin
                v1 = crd_mem[seg][j][c];
                v2 = crd_mem[seg+1][j][c];
                r = v1 + (((v2 - v1) * f) >>> 16);
                if (r > 64'sd2147483647) r = 64'sd2147483647;
                if (r < -64'sd2147483648) r = -64'sd2147483648;
              end
              default: r = 0;
            endcase
            if (c == 0) o.x = r[31:0];
            else if (c == 1) o.y = r[31:0];
            else o.z = r[31:0];
          end
          o.last = (j + 1 == nc);
          coord_q.push_back(o);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_err(string msg);
    $display("ERROR cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  // input stream driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_item(cur);
      if (!in_tvalid || in_tready) begin
        if (pend_q.size() > 0 && $urandom_range(0, 99) >= send_pct) begin
          cur = pend_q.pop_front();
          in_tdata <= {2'b00, cur.fraction, cur.data_value, cur.component,
                       cur.coord_index, cur.key_index, cur.cmd};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result stream monitor
  always @(posedge clk) begin
    coord_res_t e;
    if (rst_n) begin
      out_tready <= ($urandom_range(0, 99) >= recv_pct);
      if (out_tvalid && out_tready) begin
        if (coord_q.size() == 0) begin
          report_err("result transfer with nothing expected");
        end else begin
          e = coord_q.pop_front();
          if (out_tdata[5:0] !== e.index)
            report_err($sformatf("index got %0d exp %0d", out_tdata[5:0], e.index));
          if (out_tdata[37:6] !== e.x)
            report_err($sformatf("x[%0d] got %h exp %h", e.index, out_tdata[37:6], e.x));
          if (out_tdata[69:38] !== e.y)
            report_err($sformatf("y[%0d] got %h exp %h", e.index, out_tdata[69:38], e.y));
          if (out_tdata[101:70] !== e.z)
            report_err($sformatf("z[%0d] got %h exp %h", e.index, out_tdata[101:70], e.z));
          if (out_tlast !== e.last)
            report_err($sformatf("last[%0d] got %b exp %b", e.index, out_tlast, e.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("keyframe_vector_lerp test failed");
      $finish;
    end
  end

  function automatic lerp_cmd_t rand_cmd();
    lerp_cmd_t it;
    it.cmd = 2'($urandom);
    it.key_index = 4'($urandom);
    it.coord_index = 6'($urandom);
    it.component = 2'($urandom);
    it.data_value = $urandom;
    it.fraction = $urandom;
    return it;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic push_key(int k, longint v);
    lerp_cmd_t it;
    it = rand_cmd();
    it.cmd = CMD_KEY;
    it.key_index = 4'(k);
    it.data_value = v[31:0];
    gen_keys[k] = longint'(it.data_value);
    pend_q.push_back(it);
  endtask

  task automatic push_coord(int k, int c, int comp, logic [31:0] v);
    lerp_cmd_t it;
    it = rand_cmd();
    it.cmd = CMD_COORD;
    it.key_index = 4'(k);
    it.coord_index = 6'(c);
    it.component = 2'(comp);
    it.data_value = v;
    if (comp < 3) crd_written[k][c][comp] = 1'b1;
    pend_q.push_back(it);
  endtask

  task automatic push_apply(longint fr);
    lerp_cmd_t it;
    it = rand_cmd();
    it.cmd = CMD_APPLY;
    it.fraction = clamp32(fr);
    pend_q.push_back(it);
  endtask

  task automatic push_noise();
    lerp_cmd_t it;
    it = rand_cmd();
    it.cmd = CMD_NONE;
    pend_q.push_back(it);
  endtask

  task automatic fill_sets();
    for (int k = 0; k < gen_nk; k++)
      for (int c = 0; c < gen_nc; c++)
        for (int p = 0; p < 3; p++)
          if (!crd_written[k][c][p]) push_coord(k, c, p, $urandom);
  endtask

  task automatic new_keys();
    longint v;
    if ($urandom_range(0, 5) == 0) begin
      for (int k = 0; k < gen_nk; k++) push_key(k, longint'(signed'($urandom)));
    end else begin
      v = longint'(signed'($urandom)) >>> 2;
      for (int k = 0; k < gen_nk; k++) begin
        push_key(k, v);
        v += ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 32'h40000);
      end
    end
  endtask

  function automatic longint pick_frac();
    longint lo, hi, a, b;
    int i;
    lo = gen_keys[0];
    hi = gen_keys[gen_nk-1];
    case ($urandom_range(0, 9))
      0: return lo - $urandom_range(1, 1 << 20);
      1: return hi + $urandom_range(1, 1 << 20);
      2: return gen_keys[$urandom_range(0, gen_nk - 1)];
      3: return longint'(signed'($urandom));
      default: begin
        if (gen_nk < 2) return lo;
        i = $urandom_range(0, gen_nk - 2);
        a = (gen_keys[i] < gen_keys[i+1]) ? gen_keys[i] : gen_keys[i+1];
        b = (gen_keys[i] < gen_keys[i+1]) ? gen_keys[i+1] : gen_keys[i];
        return a + (longint'($urandom) % (b - a + 1));
      end
    endcase
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [6:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_KEY_COUNT) key_count_q = val[4:0];
    else if (idx == CFG_COORDS) coords_q = val;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pend_q.size() != 0 || in_tvalid || coord_q.size() != 0);
  endtask

  task automatic set_cfg(int kc, int cc);
    wait_drained();
    repeat (40) @(posedge clk);
    write_reg(CFG_KEY_COUNT, 7'(kc));
    write_reg(CFG_COORDS, 7'(cc));
    gen_nk = kc & 31;
    if (gen_nk < 1) gen_nk = 1;
    if (gen_nk > MAX_KEYS) gen_nk = MAX_KEYS;
    gen_nc = (cc < 1) ? 1 : (cc > MAX_COORDS) ? MAX_COORDS : cc;
  endtask

  task automatic random_phase(int kc, int cc, int n);
    set_cfg(kc, cc);
    new_keys();
    fill_sets();
    repeat (n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: push_apply(pick_frac());
        5: push_key($urandom_range(0, gen_nk - 1), pick_frac());
        6, 7: push_coord($urandom_range(0, MAX_KEYS - 1), $urandom_range(0, MAX_COORDS - 1),
                         $urandom_range(0, 2), $urandom);
        8: push_noise();
        default: push_coord($urandom_range(0, MAX_KEYS - 1), $urandom_range(0, MAX_COORDS - 1),
                            3, $urandom);
      endcase
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // extreme keys, ignored register index, ignored commands
    set_cfg(2, 3);
    write_reg(CFG_UNUSED, 7'h7F);
    push_key(0, -64'sd2147483648);
    push_key(1, 64'sd2147483647);
    fill_sets();
    push_apply(-64'sd2147483648);
    push_apply(64'sd2147483647);
    push_apply(0);
    push_apply(-1);
    push_noise();
    push_coord(0, 0, 3, 32'hFFFF_FFFF);
    push_apply(0);

    // single key: below, above, and equal gives zero vectors
    set_cfg(0, 0);
    push_key(0, 32'h0001_0000);
    fill_sets();
    push_apply(32'h0001_0000);
    push_apply(0);
    push_apply(32'h0002_0000);

    // zero-width first interval, descending last key
    set_cfg(4, 2);
    push_key(0, 0);
    push_key(1, 0);
    push_key(2, 32'h0003_0000);
    push_key(3, 32'h0001_0000);
    fill_sets();
    push_apply(0);
    push_apply(32'h0001_8000);
    push_apply(32'h0001_0000);
    push_apply(32'h0002_0000);
    push_apply(-1);

    send_pct = 82;
    recv_pct = 8;
    random_phase(5, 2, 15);

    send_pct = 0;
    recv_pct = 0;
    random_phase(1, 1, 12);
    random_phase(3, 2, 15);

    wait_drained();
    repeat (200) @(posedge clk);
    if (errors == 0 && coord_q.size() == 0) begin
      $display("keyframe_vector_lerp test passed");
    end else begin
      $display("keyframe_vector_lerp test failed");
    end
    $finish;
  end
endmodule

@@ files.f @@
sv/kvl_pkg.sv
sv/kvl_ram.sv
sv/kvl_div.sv
sv/keyframe_vector_lerp.sv
bench/testbench.sv
